// ===== rtl/core/dq_pkg.sv =====
// shared types and codes for the double-ended queue
package dq_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 5;

  typedef logic signed [WordW-1:0] word_t;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_REAR  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic f_ins;  // front-ordered lane: shift toward the tail, insert at cell 0
    logic f_shl;  // front-ordered lane: shift toward cell 0
    logic f_wr;   // front-ordered lane: write at the cell indexed by the count
    logic r_ins;  // rear-ordered lane: shift toward the tail, insert at cell 0
    logic r_shl;  // rear-ordered lane: shift toward cell 0
    logic r_wr;   // rear-ordered lane: write at the cell indexed by the count
  } cell_ctl_t;

endpackage

// ===== rtl/core/dq_cell.sv =====
// one storage cell of the deque chain, holding a front-ordered and a rear-ordered word
module dq_cell #(
  parameter int unsigned CNT_W = 5,
  parameter int unsigned IDX   = 0
) (
  input  logic               clk_i,
  input  dq_pkg::cell_ctl_t  ctl_i,
  input  logic [CNT_W-1:0]   count_i,
  input  dq_pkg::word_t      value_i,
  input  dq_pkg::word_t      f_prev_i,
  input  dq_pkg::word_t      f_next_i,
  input  dq_pkg::word_t      r_prev_i,
  input  dq_pkg::word_t      r_next_i,
  output dq_pkg::word_t      f_o,
  output dq_pkg::word_t      r_o
);

  localparam logic [CNT_W-1:0] IdxC = CNT_W'(IDX);

  dq_pkg::word_t f_q, f_d;
  dq_pkg::word_t r_q, r_d;
  logic          hit;

  assign hit = (count_i == IdxC);

  always_comb begin
    f_d = f_q;
    if (ctl_i.f_ins) begin
      f_d = f_prev_i;
    end else if (ctl_i.f_shl) begin
      f_d = f_next_i;
    end else if (ctl_i.f_wr && hit) begin
      f_d = value_i;
    end
  end

  always_comb begin
    r_d = r_q;
    if (ctl_i.r_ins) begin
      r_d = r_prev_i;
    end else if (ctl_i.r_shl) begin
      r_d = r_next_i;
    end else if (ctl_i.r_wr && hit) begin
      r_d = value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q <= f_d;
    r_q <= r_d;
  end

  assign f_o = f_q;
  assign r_o = r_q;

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// double-ended queue of signed words built as a chain of shifting cells
//
// one request channel (in_valid_i / in_stall_o) carries req_type_i and value_i;
// one result channel (out_valid_o / out_stall_i) returns front and rear words,
// the empty flag, the entry count and a status for every request.
// the words sit in two lanes of DEPTH cells: one ordered from the front, one
// ordered from the rear, so both ends are always read at cell 0. a push shifts
// one lane by a cell and writes the other lane at the cell that the count
// selects; a pop shifts only the lane of its own end toward cell 0.
// the result appears in the cycle after its request is accepted; one request is
// taken every cycle while the result side does not stall.
// the result is read straight from the cell state and a status register, which
// only change when a new request is accepted, so a stalled result holds and the
// block stalls requests until it is taken (a result taken in the same cycle
// frees the way for the next request).
// reset clears the count, the status and the result valid; cell contents are
// left as they are and are never shown before being written.
// a pop when empty returns underflow, a push when full returns overflow, and
// neither changes the queue.
module double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  req_type_i,
  input  logic signed [31:0]          value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [31:0]          front_value_o,
  output logic signed [31:0]          rear_value_o,
  output logic                        is_empty_o,
  output logic [dq_pkg::CountW-1:0]   entry_count_o,
  output logic [1:0]                  status_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FullC = CNT_W'(DEPTH);

  logic              out_valid_q, out_valid_d;
  logic [CNT_W-1:0]  count_q, count_d;
  dq_pkg::status_e   status_q, status_d;
  dq_pkg::cell_ctl_t ctl;
  logic              accept;
  logic              full, empty;
  dq_pkg::req_e      req;
  dq_pkg::word_t     f_w [DEPTH];
  dq_pkg::word_t     r_w [DEPTH];
  logic [CNT_W+dq_pkg::CountW-1:0] count_ext;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == FullC);
  assign empty      = (count_q == '0);
  assign req        = dq_pkg::req_e'(req_type_i);

  always_comb begin
    ctl      = '0;
    count_d  = count_q;
    status_d = status_q;
    if (accept) begin
      status_d = dq_pkg::ST_OK;
      case (req)
        dq_pkg::REQ_PUSH_FRONT: begin
          if (full) begin
            status_d = dq_pkg::ST_OVERFLOW;
          end else begin
            ctl.f_ins = 1'b1;
            ctl.r_wr  = 1'b1;
            count_d   = count_q + 1'b1;
          end
        end
        dq_pkg::REQ_PUSH_REAR: begin
          if (full) begin
            status_d = dq_pkg::ST_OVERFLOW;
          end else begin
            ctl.r_ins = 1'b1;
            ctl.f_wr  = 1'b1;
            count_d   = count_q + 1'b1;
          end
        end
        dq_pkg::REQ_POP_FRONT: begin
          if (empty) begin
            status_d = dq_pkg::ST_UNDERFLOW;
          end else begin
            ctl.f_shl = 1'b1;
            count_d   = count_q - 1'b1;
          end
        end
        dq_pkg::REQ_POP_REAR: begin
          if (empty) begin
            status_d = dq_pkg::ST_UNDERFLOW;
          end else begin
            ctl.r_shl = 1'b1;
            count_d   = count_q - 1'b1;
          end
        end
        default: begin
          status_d = dq_pkg::ST_OK;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
      status_q    <= dq_pkg::ST_OK;
    end else begin
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      status_q    <= status_d;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dq_pkg::word_t f_prev, f_next, r_prev, r_next;

    if (i == 0) begin : g_head
      assign f_prev = value_i;
      assign r_prev = value_i;
    end else begin : g_body
      assign f_prev = f_w[i-1];
      assign r_prev = r_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign f_next = '0;
      assign r_next = '0;
    end else begin : g_link
      assign f_next = f_w[i+1];
      assign r_next = r_w[i+1];
    end

    dq_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .count_i  (count_q),
      .value_i  (value_i),
      .f_prev_i (f_prev),
      .f_next_i (f_next),
      .r_prev_i (r_prev),
      .r_next_i (r_next),
      .f_o      (f_w[i]),
      .r_o      (r_w[i])
    );
  end

  assign count_ext     = {{dq_pkg::CountW{1'b0}}, count_q};
  assign out_valid_o   = out_valid_q;
  assign front_value_o = empty ? '0 : f_w[0];
  assign rear_value_o  = empty ? '0 : r_w[0];
  assign is_empty_o    = empty;
  assign entry_count_o = count_ext[dq_pkg::CountW-1:0];
  assign status_o      = status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullC)
    else $error("entry count above depth");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == dq_pkg::ST_OVERFLOW) |-> full)
    else $error("overflow reported while not full");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == dq_pkg::ST_UNDERFLOW) |-> empty)
    else $error("underflow reported while not empty");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !full && ((req == dq_pkg::REQ_PUSH_FRONT) || (req == dq_pkg::REQ_PUSH_REAR))
    |=> count_q == $past(count_q) + 1'b1)
    else $error("push did not raise the count");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(count_q) && $stable(status_q))
    else $error("state changed while the result was stalled");

endmodule

// ===== tb/deque_checker.sv =====
// checker that predicts every double-ended queue result and compares it field by field
`timescale 1ns / 1ps
module deque_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [1:0]                  req_type_i,
  input  logic signed [31:0]          value_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic signed [31:0]          front_value_i,
  input  logic signed [31:0]          rear_value_i,
  input  logic                        is_empty_i,
  input  logic [dq_pkg::CountW-1:0]   entry_count_i,
  input  logic [1:0]                  status_i,
  output int                          errors_o,
  output int                          pending_o,
  output int                          checked_o,
  output int                          underflows_o,
  output int                          overflows_o
);

  typedef struct {
    dq_pkg::word_t             front;
    dq_pkg::word_t             rear;
    logic                      empty;
    logic [dq_pkg::CountW-1:0] count;
    dq_pkg::status_e           status;
  } deque_view_t;

  dq_pkg::word_t             slots [DEPTH];
  int unsigned               head;
  logic [dq_pkg::CountW-1:0] held;
  deque_view_t               views_due [$];
  deque_view_t               want;

  function automatic int unsigned wrap(input int unsigned idx);
    return idx % DEPTH;
  endfunction

  // advance the shadow deque by one request and return what the block must show
  function automatic deque_view_t apply_request(input dq_pkg::req_e req,
                                                input dq_pkg::word_t word);
    deque_view_t v;
    v.status = dq_pkg::ST_OK;
    case (req)
      dq_pkg::REQ_PUSH_FRONT, dq_pkg::REQ_PUSH_REAR: begin
        if (held >= DEPTH) begin
          v.status = dq_pkg::ST_OVERFLOW;
        end else if (req == dq_pkg::REQ_PUSH_FRONT) begin
          head = wrap(head + DEPTH - 1);
          slots[head] = word;
          held = held + 1'b1;
        end else begin
          slots[wrap(head + held)] = word;
          held = held + 1'b1;
        end
      end
      default: begin
        if (held == 0) begin
          v.status = dq_pkg::ST_UNDERFLOW;
        end else begin
          if (req == dq_pkg::REQ_POP_FRONT) head = wrap(head + 1);
          held = held - 1'b1;
        end
      end
    endcase
    v.front = (held != 0) ? slots[head] : '0;
    v.rear  = (held != 0) ? slots[wrap(head + held - 1)] : '0;
    v.empty = (held == 0);
    v.count = held;
    return v;
  endfunction

  task automatic report_error(input string msg);
    errors_o++;
    $display("[%0t] deque mismatch: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head = 0;
      held = '0;
      views_due.delete();
      errors_o     = 0;
      checked_o    = 0;
      underflows_o = 0;
      overflows_o  = 0;
      pending_o   <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (views_due.size() == 0) begin
          report_error("result arrived with no request waiting");
        end else begin
          want = views_due.pop_front();
          checked_o++;
          if (want.status == dq_pkg::ST_UNDERFLOW) underflows_o++;
          if (want.status == dq_pkg::ST_OVERFLOW) overflows_o++;
          if (front_value_i !== want.front)
            report_error($sformatf("front_value %0d, predicted %0d", front_value_i, want.front));
          if (rear_value_i !== want.rear)
            report_error($sformatf("rear_value %0d, predicted %0d", rear_value_i, want.rear));
          if (is_empty_i !== want.empty)
            report_error($sformatf("is_empty %b, predicted %b", is_empty_i, want.empty));
          if (entry_count_i !== want.count)
            report_error($sformatf("entry_count %0d, predicted %0d", entry_count_i, want.count));
          if (status_i !== want.status)
            report_error($sformatf("status %0d, predicted %s", status_i, want.status.name()));
        end
      end
      // a request taken at this edge has its result at a later edge at the earliest
      if (in_valid_i && !in_stall_i)
        views_due.push_back(apply_request(dq_pkg::req_e'(req_type_i), value_i));
      pending_o <= views_due.size();
    end
  end

endmodule

// ===== tb/double_ended_queue_tb.sv =====
// top of the double-ended queue testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps
module double_ended_queue_tb;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned RandomItems  = 1800;
  localparam int unsigned PhaseCount   = 12;
  localparam int unsigned PerPhase     = RandomItems / PhaseCount;
  localparam longint      CycleLimit   = 200000;

  logic                        clk         = 1'b0;
  logic                        rst_n       = 1'b0;
  logic                        in_valid    = 1'b0;
  logic                        in_stall;
  logic [1:0]                  req_type    = dq_pkg::REQ_PUSH_FRONT;
  logic signed [31:0]          value       = '0;
  logic                        out_valid;
  logic                        out_stall   = 1'b0;
  logic signed [31:0]          front_value;
  logic signed [31:0]          rear_value;
  logic                        is_empty;
  logic [dq_pkg::CountW-1:0]   entry_count;
  logic [1:0]                  status;

  int          errors;
  int          pending;
  int          checked;
  int          underflows;
  int          overflows;
  int          sent = 0;
  int          directed = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  longint      cycles = 0;

  // share of pushes per phase: some phases fill to full, some drain to empty
  int unsigned push_bias [PhaseCount] = '{90, 55, 15, 75, 97, 30, 50, 5, 85, 40, 65, 20};

  always #4 clk = ~clk;

  double_ended_queue #(.DEPTH(DEPTH)) uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .req_type_i    (req_type),
    .value_i       (value),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .front_value_o (front_value),
    .rear_value_o  (rear_value),
    .is_empty_o    (is_empty),
    .entry_count_o (entry_count),
    .status_o      (status)
  );

  deque_checker #(.DEPTH(DEPTH)) checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .req_type_i    (req_type),
    .value_i       (value),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .front_value_i (front_value),
    .rear_value_i  (rear_value),
    .is_empty_i    (is_empty),
    .entry_count_i (entry_count),
    .status_i      (status),
    .errors_o      (errors),
    .pending_o     (pending),
    .checked_o     (checked),
    .underflows_o  (underflows),
    .overflows_o   (overflows)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("double_ended_queue verification failed");
      $finish;
    end
  end

  // offer one request, with random idle cycles ahead of it, and hold it until taken
  task automatic send_request(input dq_pkg::req_e req, input dq_pkg::word_t word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    value    <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // stop sending until every outstanding request has its result
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic dq_pkg::word_t pick_word();
    case ($urandom_range(15))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic dq_pkg::req_e pick_request(input int unsigned push_pct);
    if ($urandom_range(99) < push_pct)
      return $urandom_range(1) ? dq_pkg::REQ_PUSH_REAR : dq_pkg::REQ_PUSH_FRONT;
    return $urandom_range(1) ? dq_pkg::REQ_POP_REAR : dq_pkg::REQ_POP_FRONT;
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pops on an empty deque, extreme words at both ends, head wrap below slot 0
    send_request(dq_pkg::REQ_POP_FRONT, 32'sh12345678);
    send_request(dq_pkg::REQ_POP_REAR, 32'sh80000000);
    send_request(dq_pkg::REQ_PUSH_FRONT, 32'sh7fffffff);
    send_request(dq_pkg::REQ_PUSH_REAR, 32'sh80000000);
    send_request(dq_pkg::REQ_PUSH_FRONT, '1);
    send_request(dq_pkg::REQ_PUSH_REAR, '0);
    send_request(dq_pkg::REQ_POP_FRONT, '0);
    send_request(dq_pkg::REQ_POP_REAR, '1);
    // fill to full, then push at both ends while full
    repeat (DEPTH - 2) send_request(dq_pkg::REQ_PUSH_REAR, pick_word());
    send_request(dq_pkg::REQ_PUSH_FRONT, 32'sh5a5a5a5a);
    send_request(dq_pkg::REQ_PUSH_REAR, 32'sha5a5a5a5);
    directed = sent;
    wait_until_drained();

    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 59; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 59; end
        default: begin send_idle_pct = 12; stall_pct <= 12; end
      endcase
      repeat (PerPhase) send_request(pick_request(push_bias[phase]), pick_word());
      wait_until_drained();
    end

    repeat (8) @(posedge clk);
    $display("sent %0d requests (%0d directed) in %0d cycles across %0d idle/stall phases",
             sent, directed, cycles, PhaseCount);
    $display("checked %0d results including %0d underflows and %0d overflows, %0d mismatches",
             checked, underflows, overflows, errors);
    if (errors == 0) begin
      $display("double_ended_queue verification clean");
    end else begin
      $display("double_ended_queue verification failed");
    end
    $finish;
  end

endmodule
